@@ rtl/ptdt_pkg.sv @@
// Shared constants for the periodic task dispatch timer.
// No dependencies; imported by the top level.
`default_nettype none

package ptdt_pkg;

	// default number of task slots
	localparam int SLOT_COUNT_DEF = 8;

	// field widths
	localparam int SLOT_W   = 8;
	localparam int TIME_W   = 16;
	localparam int TASK_W   = 4;
	localparam int DIV_W    = 8;

	// tick_divide after reset
	localparam logic [DIV_W-1:0] TICK_DIVIDE_RESET = 8'd5;

	// action codes
	localparam logic ACTION_TICK   = 1'b0;
	localparam logic ACTION_CREATE = 1'b1;

endpackage

`default_nettype wire

@@ rtl/ptdt_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ptdt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/periodic_task_dispatch_timer_top.sv @@
// Periodic task dispatch timer: slot table in RAM, prescaler and pass walker.
// Depends on ptdt_pkg and ptdt_ram.
//
//   channel | signals                                     | role
//   --------+---------------------------------------------+--------------------------
//   in      | in_valid in_stall action task_slot period   | tick or create beats
//           | first_delay has_handler                     |
//   out     | out_valid out_stall task_index last         | one beat per dispatched slot
//   cfg     | cfg_valid cfg_ready cfg_data                | tick_divide write
//
// A create, or a tick that does not end a prescaler round, is taken without raising in_stall.
// A tick that starts a pass walks the slot RAM one entry per cycle through
// its single read port, except while the walk is frozen as described below,
// then passes through the flush state; in_stall is high from walk to flush.
// Stalls on the out channel freeze the walk only when a second dispatch finds
// the output register still occupied; the last beat of a pass likewise waits
// in the flush state until the output register is free.
// Reset clears valid marks, prescaler and control; slot RAM needs no clearing.
`default_nettype none

module periodic_task_dispatch_timer_top
	import ptdt_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              action,
	input  wire logic [SLOT_W-1:0] task_slot,
	input  wire logic [TIME_W-1:0] period,
	input  wire logic [TIME_W-1:0] first_delay,
	input  wire logic              has_handler,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [TASK_W-1:0]      task_index,
	output logic                   last,
	// configuration channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [DIV_W-1:0]  cfg_data
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int ENT_W = 2 * TIME_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t                 state_q;
	logic [DIV_W-1:0]       tick_div_q;
	logic [DIV_W-1:0]       prescale_q;
	logic [SLOT_COUNT-1:0]  valid_q;
	logic [CNT_W-1:0]       rd_cnt_q;
	logic                   busy_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   pend_q;
	logic [IDX_W-1:0]       pend_idx_q;
	logic                   out_valid_q;
	logic [TASK_W-1:0]      out_idx_q;
	logic                   out_last_q;

	logic                   in_acc;
	logic                   create_ok;
	logic [DIV_W-1:0]       prescale_nxt;
	logic                   issue;
	logic                   out_free;
	logic                   blocked;
	logic                   advance;
	logic                   out_load;
	logic [TIME_W-1:0]      cd_s1;
	logic [TIME_W-1:0]      per_s1;
	logic                   zero_s1;
	logic                   dispatch_s1;
	logic [TIME_W-1:0]      cd_new_s1;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENT_W-1:0]       ram_wdata;
	logic                   ram_re;
	logic [ENT_W-1:0]       ram_rdata;

	// handshakes
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign create_ok = (task_slot < SLOT_W'(SLOT_COUNT)) && has_handler;
	assign prescale_nxt = prescale_q + 1'b1;

	// walk control
	assign issue    = (rd_cnt_q < CNT_W'(SLOT_COUNT));
	assign out_free = !out_valid_q || !out_stall;

	// entry read-modify
	assign cd_s1       = ram_rdata[TIME_W-1:0];
	assign per_s1      = ram_rdata[ENT_W-1:TIME_W];
	assign zero_s1     = (cd_s1 == '0);
	assign cd_new_s1   = zero_s1 ? (per_s1 - 1'b1) : (cd_s1 - 1'b1);
	assign dispatch_s1 = zero_s1 && valid_q[idx_s1];

	// a second dispatch needs the pending beat moved into a free output register
	assign blocked = busy_s1 && dispatch_s1 && pend_q && !out_free;
	assign advance = (state_q == ST_WALK) && !blocked;

	// pending beat moves out on its successor's dispatch or in the flush state
	assign out_load = pend_q && ((advance && busy_s1 && dispatch_s1) ||
		((state_q == ST_FLUSH) && out_free));

	// RAM ports: creates write while idle, the walk writes back the modified entry
	always_comb begin
		if (state_q == ST_IDLE) begin
			ram_we    = in_acc && (action == ACTION_CREATE) && create_ok;
			ram_waddr = task_slot[IDX_W-1:0];
			ram_wdata = {period, first_delay};
		end else begin
			ram_we    = advance && busy_s1;
			ram_waddr = idx_s1;
			ram_wdata = {per_s1, cd_new_s1};
		end
	end

	assign ram_re = advance && issue;

	ptdt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (rd_cnt_q[IDX_W-1:0]),
		.rd_data (ram_rdata)
	);

	// sequencer, prescaler, pending and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_div_q  <= TICK_DIVIDE_RESET;
			prescale_q  <= '0;
			valid_q     <= '0;
			rd_cnt_q    <= '0;
			busy_s1     <= 1'b0;
			idx_s1      <= '0;
			pend_q      <= 1'b0;
			pend_idx_q  <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tick_div_q <= cfg_data;
			end

			// output register: load the pending beat, or drop the one taken downstream
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_idx_q   <= TASK_W'(pend_idx_q);
				out_last_q  <= (state_q == ST_FLUSH);
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (action == ACTION_CREATE) begin
							if (create_ok) begin
								valid_q[task_slot[IDX_W-1:0]] <= 1'b1;
							end
						end else if (prescale_nxt == tick_div_q) begin
							prescale_q <= '0;
							rd_cnt_q   <= '0;
							busy_s1    <= 1'b0;
							state_q    <= ST_WALK;
						end else begin
							prescale_q <= prescale_nxt;
						end
					end
				end

				ST_WALK: begin
					if (!blocked) begin
						// read stage
						if (issue) begin
							rd_cnt_q <= rd_cnt_q + 1'b1;
							idx_s1   <= rd_cnt_q[IDX_W-1:0];
							busy_s1  <= 1'b1;
						end else begin
							busy_s1 <= 1'b0;
						end
						// modify stage: hold the newest dispatch until its successor shows
						if (busy_s1 && dispatch_s1) begin
							pend_q     <= 1'b1;
							pend_idx_q <= idx_s1;
						end
						if (!issue && !busy_s1) begin
							state_q <= ST_FLUSH;
						end
					end
				end

				ST_FLUSH: begin
					// final dispatch of the pass carries last
					if (!pend_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign task_index = out_idx_q;
	assign last       = out_last_q;

endmodule

`default_nettype wire

@@ verif/tb_periodic_task_dispatch_timer_top.sv @@
// Self-checking testbench for periodic_task_dispatch_timer_top.
// Depends on ptdt_pkg and the RTL top; a built-in slot-table scheduler model
// predicts dispatch beats, apart from directed rows with a typed expectation.
`timescale 1ns / 1ps

module tb_periodic_task_dispatch_timer_top;
	import ptdt_pkg::*;

	localparam int SETTLE      = SLOT_COUNT_DEF + 16;  // cycles for a pass walk to drain
	localparam int HOLD_CYCLES = 300;                  // long receiver hold-off
	localparam int STUCK_LIMIT = 4000;                 // cycles with no beat on any channel
	localparam int IDLE_PCT    = 15;

	typedef struct packed {
		logic              action;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] first;
		logic              handler;
	} req_t;

	typedef struct packed {
		logic [TASK_W-1:0] idx;
		logic              last;
	} dispatch_t;

	// directed row: exp_n < 0 means the scheduler model decides
	typedef struct {
		req_t req;
		int   exp_n;
		int   exp_idx;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = ACTION_TICK;
	logic [SLOT_W-1:0] task_slot = '0;
	logic [TIME_W-1:0] period = '0;
	logic [TIME_W-1:0] first_delay = '0;
	logic              has_handler = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [TASK_W-1:0] task_index;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [DIV_W-1:0]  cfg_data = '0;

	// typed expectation that travels with the current input beat
	int beat_exp_n = -1;
	int beat_exp_idx = 0;

	bit quiet = 1'b0;      // no idling on either side
	bit hold_req = 1'b0;   // ask the receiver for one long hold-off

	// scheduler model state
	logic [DIV_W-1:0]  sched_div = TICK_DIVIDE_RESET;
	logic [DIV_W-1:0]  prescale = '0;
	logic [TIME_W-1:0] slot_left [SLOT_COUNT_DEF];
	logic [TIME_W-1:0] slot_per [SLOT_COUNT_DEF];
	bit                slot_live [SLOT_COUNT_DEF];
	dispatch_t         dispatch_q [$];

	row_t plan [$];
	int err_count = 0;
	int n_in = 0;
	int n_create = 0;
	int n_pass = 0;
	int n_out = 0;
	int n_cfg = 0;
	int stuck = 0;

	periodic_task_dispatch_timer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.task_slot(task_slot),
		.period(period),
		.first_delay(first_delay),
		.has_handler(has_handler),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.task_index(task_index),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic note_mismatch(string what, int got, int want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// Apply one beat to the slot table; on a pass, collect dispatches in index
	// order and queue them when keep is set. Returns the dispatch count.
	function automatic int step_scheduler(req_t r, bit keep);
		dispatch_t hits [$];
		int i;
		if (r.action == ACTION_CREATE) begin
			if (r.slot < SLOT_COUNT_DEF && r.handler) begin
				slot_left[r.slot] = r.first;
				slot_per[r.slot] = r.period;
				slot_live[r.slot] = 1'b1;
			end
			return 0;
		end
		prescale = prescale + 8'd1;
		if (prescale != sched_div)
			return 0;
		prescale = '0;
		n_pass++;
		for (i = 0; i < SLOT_COUNT_DEF; i++) begin
			if (slot_left[i] == '0) begin
				if (slot_live[i])
					hits.push_back('{idx: i[TASK_W-1:0], last: 1'b0});
				// zero period wraps to all ones
				slot_left[i] = slot_per[i] - 16'd1;
			end else begin
				slot_left[i] = slot_left[i] - 16'd1;
			end
		end
		if (hits.size() > 0)
			hits[hits.size()-1].last = 1'b1;
		if (keep)
			foreach (hits[k])
				dispatch_q.push_back(hits[k]);
		return hits.size();
	endfunction

	// Scoreboard: predict on input beats, check output beats
	always @(posedge clk or negedge arst_n) begin : scoreboard
		req_t seen;
		dispatch_t want;
		int n;
		if (!arst_n) begin
			sched_div = TICK_DIVIDE_RESET;
			prescale = '0;
			for (n = 0; n < SLOT_COUNT_DEF; n++) begin
				slot_left[n] = '0;
				slot_per[n] = '0;
				slot_live[n] = 1'b0;
			end
			dispatch_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				sched_div = cfg_data;
				n_cfg++;
			end
			if (in_valid && !in_stall) begin
				seen = {action, task_slot, period, first_delay, has_handler};
				n_in++;
				if (action == ACTION_CREATE)
					n_create++;
				if (beat_exp_n < 0) begin
					void'(step_scheduler(seen, 1'b1));
				end else begin
					// typed rows carry at most one dispatch, which is then the last
					void'(step_scheduler(seen, 1'b0));
					if (beat_exp_n > 0)
						dispatch_q.push_back('{idx: beat_exp_idx[TASK_W-1:0], last: 1'b1});
				end
			end
			if (out_valid && !out_stall) begin
				n_out++;
				if (dispatch_q.size() == 0) begin
					note_mismatch("dispatch with nothing due, task_index", task_index, -1);
				end else begin
					want = dispatch_q.pop_front();
					if (task_index !== want.idx)
						note_mismatch("task_index", task_index, want.idx);
					if (last !== want.last)
						note_mismatch("last", last, want.last);
				end
			end
		end
	end

	// Watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("[%0t] timeout: no beat for %0d cycles", $realtime, STUCK_LIMIT);
			$display("** periodic_task_dispatch_timer_top: FAILED **");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Random beat; tick beats still carry random fields
	function automatic req_t rand_req(int create_pct);
		req_t r;
		r.action = ($urandom_range(99) < create_pct) ? ACTION_CREATE : ACTION_TICK;
		r.slot = ($urandom_range(9) == 0) ? SLOT_W'($urandom)
			: SLOT_W'($urandom_range(SLOT_COUNT_DEF - 1));
		r.period = ($urandom_range(7) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(6));
		r.first = ($urandom_range(7) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(4));
		r.handler = ($urandom_range(9) != 0);
		return r;
	endfunction

	function automatic void add_row(logic act, logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] per,
			logic [TIME_W-1:0] first, logic hnd, int exp_n, int exp_idx);
		row_t row;
		row.req = {act, slot, per, first, hnd};
		row.exp_n = exp_n;
		row.exp_idx = exp_idx;
		plan.push_back(row);
	endfunction

	// Offer one input beat and wait for it to be taken
	task automatic drive_beat(req_t r, int exp_n, int exp_idx);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.action;
		task_slot <= r.slot;
		period <= r.period;
		first_delay <= r.first;
		has_handler <= r.handler;
		beat_exp_n <= exp_n;
		beat_exp_idx <= exp_idx;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random(int count, int create_pct);
		repeat (count) drive_beat(rand_req(create_pct), -1, 0);
	endtask

	// tick_divide write, only once the block has drained
	task automatic write_divide(logic [DIV_W-1:0] value);
		in_valid <= 1'b0;
		while (dispatch_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int s;
		req_t r;

		// directed plan, reset divide of 5 in force
		// four ticks, then an empty pass
		for (s = 0; s < 5; s++)
			add_row(ACTION_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 0, 0);
		// slot 0 with no delay, then ignored creates: slot just out of range,
		// top slot index, no handler
		add_row(ACTION_CREATE, 8'd0, 16'd3, 16'd0, 1'b1, 0, 0);
		add_row(ACTION_CREATE, 8'(SLOT_COUNT_DEF), 16'd1, 16'd0, 1'b1, 0, 0);
		add_row(ACTION_CREATE, 8'hFF, 16'd1, 16'd0, 1'b1, 0, 0);
		add_row(ACTION_CREATE, 8'(SLOT_COUNT_DEF - 1), 16'd0, 16'd0, 1'b0, 0, 0);
		for (s = 0; s < 4; s++)
			add_row(ACTION_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 0, 0);
		// slot 0 is due on this pass and is its only dispatch
		add_row(ACTION_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 1, 0);
		// zero period, extreme period and delay, short period
		add_row(ACTION_CREATE, 8'(SLOT_COUNT_DEF - 1), 16'd0, 16'd0, 1'b1, -1, 0);
		add_row(ACTION_CREATE, 8'd3, 16'hFFFF, 16'hFFFF, 1'b1, -1, 0);
		add_row(ACTION_CREATE, 8'd5, 16'd1, 16'd1, 1'b1, -1, 0);
		for (s = 0; s < 5; s++)
			add_row(ACTION_TICK, 8'h5A, 16'hA5A5, 16'h5A5A, 1'b1, -1, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			drive_beat(plan[i].req, plan[i].exp_n, plan[i].exp_idx);

		// every slot due each pass, then the receiver holds off while ticks keep coming
		write_divide(8'd1);
		for (s = 0; s < SLOT_COUNT_DEF; s++) begin
			r = '{action: ACTION_CREATE, slot: SLOT_W'(s), period: 16'd1, first: 16'd0,
				handler: 1'b1};
			drive_beat(r, -1, 0);
		end
		hold_req <= 1'b1;
		repeat (12) drive_beat(rand_req(0), -1, 0);

		// top divide, then lower it below the prescaler: no pass while it counts on
		write_divide(8'hFF);
		quiet = 1'b1;
		repeat (10) drive_beat(rand_req(0), -1, 0);
		write_divide(8'd4);
		repeat (3) drive_beat(rand_req(0), -1, 0);
		// raise the divide just past the prescaler, next pass two ticks later
		write_divide(prescale + 8'd2);
		repeat (2) drive_beat(rand_req(0), -1, 0);
		quiet = 1'b0;

		// random traffic, first stretch with no idling
		write_divide(8'd3);
		quiet = 1'b1;
		send_random(15, 30);
		quiet = 1'b0;
		send_random(20, 30);
		write_divide(8'd2);
		send_random(10, 25);

		// drain and let any stray dispatch show up
		in_valid <= 1'b0;
		while (dispatch_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Run covered %0d input beats (%0d creates), %0d scheduler passes,",
			n_in, n_create, n_pass);
		$display("%0d dispatch beats checked, %0d divide writes, %0d mismatches.",
			n_out, n_cfg, err_count);
		if (err_count == 0)
			$display("** periodic_task_dispatch_timer_top: PASSED **");
		else
			$display("** periodic_task_dispatch_timer_top: FAILED **");
		$finish;
	end

endmodule
